// ===== rtl/hri_pkg.sv =====
// hri_pkg: shared constants, types and controller encodings of the hall rotor angle interpolator
// no dependencies; compiled first

package hri_pkg;

  // default parameter values
  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF  = 32;

  // fixed field widths
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned PROG_W     = 14;
  localparam int unsigned NUM_SECT   = 8;
  localparam int unsigned SECT_W     = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // command codes on the input channel
  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } hri_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic mul;
    logic div_step;
    logic out_load;
  } hri_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic special;
    logic div_last;
    logic out_free;
  } hri_sts_t;

endpackage

// ===== rtl/hri_ifs.sv =====
// hri_ifs: valid/ready channel interfaces for items and results
// depends on hri_pkg

interface hri_in_if import hri_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [NOW_W-1:0]  now_us;
  logic [CODE_W-1:0] hall_code;

  modport source (output valid, command, now_us, hall_code, input ready);
  modport sink (input valid, command, now_us, hall_code, output ready);
endinterface

interface hri_out_if import hri_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] rotor_angle;
  logic [PROG_W-1:0]  sector_progress;
  logic [CODE_W-1:0]  current_hall_code;

  modport source (output valid, rotor_angle, sector_progress, current_hall_code, input ready);
  modport sink (input valid, rotor_angle, sector_progress, current_hall_code, output ready);
endinterface

// ===== rtl/hri_ctrl.sv =====
// hri_ctrl: sequencing state machine of the angle interpolator
// depends on hri_pkg; drives hri_dp through hri_cmd_t

module hri_ctrl import hri_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  hri_sts_t sts_i,
  output hri_cmd_t cmd_o
);

  hri_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = sts_i.special ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_accept_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == ST_MUL)
    else $error("accepted item did not start the multiply step");

  a_special_skips_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && sts_i.special) |=> state_q == ST_DONE)
    else $error("saturated progress went through the divider");

  a_load_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (state_q == ST_IDLE && in_ready_o))
    else $error("result load did not return to idle");

endmodule

// ===== rtl/hri_dp.sv =====
// hri_dp: edge state, sector table, multiplier, restoring divider and result register
// depends on hri_pkg; controlled by hri_ctrl

module hri_dp import hri_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_command_i,
  input  logic [NOW_W-1:0]      in_now_us_i,
  input  logic [CODE_W-1:0]     in_hall_code_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ANGLE_W-1:0]    out_rotor_angle_o,
  output logic [PROG_W-1:0]     out_sector_progress_o,
  output logic [CODE_W-1:0]     out_current_hall_code_o,
  input  hri_cmd_t              cmd_i,
  output hri_sts_t              sts_o
);

  localparam int unsigned PB    = ANGLE_BITS - 2;
  localparam int unsigned NW    = TIME_BITS + PB;
  localparam int unsigned CNT_W = $clog2(PB);
  localparam int unsigned SPAN  = ((2 ** ANGLE_BITS) + 3) / 6;

  logic [PB-1:0] span_v;
  assign span_v = PB'(SPAN);

  // sector base angle table
  logic [CFG_DATA_W-1:0] sect_q [NUM_SECT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SECT; i++) begin
        sect_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_SECT))) begin
      sect_q[cfg_idx_i[SECT_W-1:0]] <= cfg_data_i;
    end
  end

  // edge state
  logic [TIME_BITS-1:0] last_q, interval_q, now_q, now_w, elapsed;
  logic [CODE_W-1:0]    code_q;
  logic                 seen_q;
  logic                 command_q;

  assign now_w = TIME_BITS'(in_now_us_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= '0;
      interval_q <= '0;
      code_q     <= '0;
      seen_q     <= 1'b0;
    end else if (cmd_i.accept && in_command_i == CMD_EDGE) begin
      interval_q <= now_w - last_q;
      last_q     <= now_w;
      code_q     <= in_hall_code_i;
      seen_q     <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      now_q     <= now_w;
      command_q <= in_command_i;
    end
  end

  // saturation check and product, in parallel
  logic          special_w;
  logic [NW-1:0] prod_w;

  assign elapsed   = now_q - last_q;
  assign special_w = !seen_q || (interval_q == '0) || (elapsed >= interval_q);
  assign prod_w    = NW'(elapsed) * NW'(span_v);

  // restoring divider, one quotient bit a step
  logic [TIME_BITS-1:0] rem_q;
  logic [PB-1:0]        quo_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 special_q;
  logic [PB-1:0]        sprog_q;
  logic [TIME_BITS:0]   trial, diff;
  logic                 ge;

  assign trial = {rem_q, quo_q[PB-1]};
  assign diff  = trial - {1'b0, interval_q};
  assign ge    = trial >= {1'b0, interval_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      rem_q     <= prod_w[NW-1:PB];
      quo_q     <= prod_w[PB-1:0];
      cnt_q     <= '0;
      special_q <= special_w;
      sprog_q   <= seen_q ? span_v : '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      quo_q <= {quo_q[PB-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign sts_o.special  = special_w;
  assign sts_o.div_last = (cnt_q == CNT_W'(PB - 1));
  assign sts_o.out_free = !out_valid_o || out_ready_i;

  // result
  logic [PB-1:0]         prog_res;
  logic [ANGLE_BITS-1:0] base_w, angle_w;

  assign prog_res = special_q ? sprog_q : quo_q;
  assign base_w   = ANGLE_BITS'(sect_q[code_q]);
  assign angle_w  = base_w + ANGLE_BITS'(prog_res);

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_rotor_angle_o       <= ANGLE_W'(angle_w);
      out_sector_progress_o   <= PROG_W'(prog_res);
      out_current_hall_code_o <= code_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_prog_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> prog_res <= span_v)
    else $error("progress above one sector span");

  a_edge_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && command_q == CMD_EDGE) |-> (prog_res == '0 || prog_res == span_v))
    else $error("edge result with nonzero interpolated progress");

  a_no_edge_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && !seen_q) |-> prog_res == '0)
    else $error("progress before first edge");

endmodule

// ===== rtl/hall_rotor_angle_interpolator.sv =====
// hall rotor angle interpolator: an accepted item goes through one multiply step,
// ANGLE_BITS-2 restoring divider steps and the result load, or skips the divider when no
// edge has been seen yet or the progress is saturated; the result load waits while an unread
// result is held; one item at a time; the result register lets the next item enter while a
// result waits; asynchronous active-low reset clears the sector table, the edge state (time,
// interval, code, edge seen) and the handshake control
// depends on hri_pkg, hri_ifs, hri_ctrl and hri_dp

module hall_rotor_angle_interpolator import hri_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  hri_in_if.sink                req_i,
  hri_out_if.source             rsp_o
);

  // command and status between sequencer and datapath
  hri_cmd_t cmd;
  hri_sts_t sts;

  // sequencer: idle -> multiply -> divide steps (skipped when no edge was seen or progress saturates) -> result load
  hri_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: edge state, base angle table, product, divider and result register
  hri_dp #(
    .ANGLE_BITS (ANGLE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_idx_i               (cfg_idx_i),
    .cfg_data_i              (cfg_data_i),
    .in_command_i            (req_i.command),
    .in_now_us_i             (req_i.now_us),
    .in_hall_code_i          (req_i.hall_code),
    .out_valid_o             (rsp_o.valid),
    .out_ready_i             (rsp_o.ready),
    .out_rotor_angle_o       (rsp_o.rotor_angle),
    .out_sector_progress_o   (rsp_o.sector_progress),
    .out_current_hall_code_o (rsp_o.current_hall_code),
    .cmd_i                   (cmd),
    .sts_o                   (sts)
  );

endmodule
